// ----- sv/vta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vta_pkg: shared types and constants of the vertex tangent accumulator
// Request kinds, sequencer states, vertex store sizing and the divider
// request and response records.
// ----------------------------------------------------------------------------
package vta_pkg;

    localparam int COORD_BITS    = 16;
    localparam int VERTEX_COUNT  = 1024;
    localparam int ADDR_BITS     = $clog2(VERTEX_COUNT);
    localparam int DIVIDEND_BITS = 48;
    localparam int DIVISOR_BITS  = 36;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_TRI  = 2'd1,
        ACT_READ = 2'd2,
        ACT_NOP  = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TRD_A,
        ST_TRD_B,
        ST_TRD_C,
        ST_TCAP_C,
        ST_TMUL,
        ST_TDIV_GO,
        ST_TDIV_WAIT,
        ST_SUM_RD,
        ST_SUM_WR,
        ST_RRD,
        ST_RCAP,
        ST_RNORM,
        ST_RSQ,
        ST_RSQRT,
        ST_RDIV_GO,
        ST_RDIV_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [DIVISOR_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [DIVIDEND_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- sv/vertex_tangent_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_tangent_accumulator: per-vertex tangent builder for a triangle mesh
// Stores vertex positions and texture coordinates, accumulates saturating
// Q20.12 tangent sums per triangle and returns unit tangents in Q1.14.
// ----------------------------------------------------------------------------
// A request is a load, a triangle, a read or a no-op, chosen by s_tuser. A
// load writes one vertex's position and texture coordinate and clears its
// tangent sum; it completes in the accept cycle and gives no result. A
// triangle reads its three corners, forms the edges and the UV deltas, forms
// the UV determinant and the numerators on a shared 33x33 multiplier, divides
// each numerator (shifted by 12) by the determinant and adds the saturated
// tangent to each corner sum in the order a, b, c; a zero determinant leaves
// the sums alone and ends the request after the products. A read fetches one
// sum, shifts it up until its largest magnitude reaches 2^30, squares and
// sums the parts, takes an integer square root and divides each part by the
// length with rounding; a zero sum returns zeros with the zero_sum flag. The
// divider gives one quotient bit per cycle and is used three times per
// triangle or read. The block takes one request at a time; s_tready is high
// only while it is idle. The vertex stores come up undefined: a vertex must
// be loaded before a triangle or read names it.
// ----------------------------------------------------------------------------
module vertex_tangent_accumulator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_slot[9:0], pos_x[25:10], pos_y[41:26], pos_z[57:42],
    // tex_u[73:58], tex_v[89:74], corner_a[99:90], corner_b[109:100],
    // corner_c[119:110], zero fill [127:120]
    input  logic [127:0] s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertex_number[9:0], tangent_x[25:10], tangent_y[41:26],
    // tangent_z[57:42], zero fill [63:58]
    output logic [63:0]  m_tdata,
    // zero_sum[0]
    output logic [0:0]   m_tuser
);
    import vta_pkg::*;

    // Sign-extended difference of two coordinates.
    function automatic logic signed [COORD_BITS:0] cdiff(logic [COORD_BITS-1:0] p,
                                                       logic [COORD_BITS-1:0] q);
        return $signed({p[COORD_BITS-1], p}) - $signed({q[COORD_BITS-1], q});
    endfunction

    // Saturating 32-bit add.
    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Vertex stores
    // ------------------------------------------------------------------
    logic [3*COORD_BITS-1:0] pos_mem [VERTEX_COUNT];
    logic [2*COORD_BITS-1:0] tex_mem [VERTEX_COUNT];
    logic [95:0]             sum_mem [VERTEX_COUNT];

    logic [3*COORD_BITS-1:0] pos_q;
    logic [2*COORD_BITS-1:0] tex_q;
    logic [95:0]             sum_q;
    logic [ADDR_BITS-1:0]    rd_addr;
    logic                    load_we;
    logic                    sum_we;
    logic [ADDR_BITS-1:0]    sum_waddr;
    logic [95:0]             sum_wdata;

    // Input fields
    logic                  s_accept;
    action_t               in_action;
    logic [ADDR_BITS-1:0]  in_slot;
    logic [ADDR_BITS-1:0]  in_corner [3];

    // Sequencer and command
    state_t                state_reg, state_next;
    logic [4:0]            step_reg, step_next;
    logic [1:0]            idx_reg, idx_next;
    logic [ADDR_BITS-1:0]  slot_reg, slot_next;
    logic [ADDR_BITS-1:0]  corner_reg [3];
    logic [ADDR_BITS-1:0]  corner_next [3];

    // Triangle datapath
    logic [3*COORD_BITS-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic [2*COORD_BITS-1:0] ta_reg, ta_next, tb_reg, tb_next;
    logic signed [COORD_BITS:0] du1_reg, du1_next, dv1_reg, dv1_next;
    logic signed [COORD_BITS:0] du2_reg, du2_next, dv2_reg, dv2_next;
    logic signed [COORD_BITS:0] e1_reg [3];
    logic signed [COORD_BITS:0] e1_next [3];
    logic signed [COORD_BITS:0] e2_reg [3];
    logic signed [COORD_BITS:0] e2_next [3];
    logic signed [35:0]      pfirst_reg, pfirst_next;
    logic signed [36:0]      dn_reg [4];
    logic signed [36:0]      dn_next [4];
    logic [31:0]             t_reg [3];
    logic [31:0]             t_next [3];

    // Shared multiplier
    logic signed [32:0]      mul_a, mul_b;
    logic signed [65:0]      prod_reg;

    // Read datapath
    logic                    neg_reg [3];
    logic                    neg_next [3];
    logic [31:0]             mag_reg [3];
    logic [31:0]             mag_next [3];
    logic [63:0]             s_reg, s_next;
    logic [63:0]             x_reg, x_next;
    logic [63:0]             r_reg, r_next;
    logic [63:0]             bit_reg, bit_next;
    logic [15:0]             tout_reg [3];
    logic [15:0]             tout_next [3];
    logic                    zero_reg, zero_next;

    // Output stage
    logic                    m_valid_reg, m_valid_next;
    logic [63:0]             m_data_reg, m_data_next;
    logic                    m_zero_reg, m_zero_next;

    // Divider
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    // Scratch
    logic signed [36:0]      n_sel;
    logic [35:0]             n_abs, det_abs;
    logic [47:0]             q;
    logic [31:0]             mag_or;
    logic [63:0]             trial;
    logic [2:0]              jstep;
    logic [31:0]             c_word;

    vta_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_action = action_t'(s_tuser);
    assign in_slot   = s_tdata[9:0];
    assign in_corner[0] = s_tdata[99:90];
    assign in_corner[1] = s_tdata[109:100];
    assign in_corner[2] = s_tdata[119:110];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_zero_reg;

    // Write on load, or on a sum update; read one address per cycle.
    assign load_we = s_accept && (in_action == ACT_LOAD);

    always_ff @(posedge aclk) begin
        if (load_we) begin
            pos_mem[in_slot] <= s_tdata[57:10];
            tex_mem[in_slot] <= s_tdata[89:58];
        end
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        pos_q <= pos_mem[rd_addr];
        tex_q <= tex_mem[rd_addr];
        sum_q <= sum_mem[rd_addr];
    end

    // Shared multiplier: operands picked by the sequencer, product registered.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_TMUL) begin
            unique case (step_reg[2:0])
                3'd0: begin mul_a = 33'(du1_reg);   mul_b = 33'(dv2_reg);   end
                3'd1: begin mul_a = 33'(du2_reg);   mul_b = 33'(dv1_reg);   end
                3'd2: begin mul_a = 33'(dv2_reg);   mul_b = 33'(e1_reg[0]); end
                3'd3: begin mul_a = 33'(dv1_reg);   mul_b = 33'(e2_reg[0]); end
                3'd4: begin mul_a = 33'(dv2_reg);   mul_b = 33'(e1_reg[1]); end
                3'd5: begin mul_a = 33'(dv1_reg);   mul_b = 33'(e2_reg[1]); end
                3'd6: begin mul_a = 33'(dv2_reg);   mul_b = 33'(e1_reg[2]); end
                3'd7: begin mul_a = 33'(dv1_reg);   mul_b = 33'(e2_reg[2]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (state_reg == ST_RSQ && step_reg[1:0] != 2'd3) begin
            mul_a = $signed({1'b0, mag_reg[step_reg[1:0]]});
            mul_b = $signed({1'b0, mag_reg[step_reg[1:0]]});
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        corner_next  = corner_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        ta_next      = ta_reg;
        tb_next      = tb_reg;
        du1_next     = du1_reg;
        dv1_next     = dv1_reg;
        du2_next     = du2_reg;
        dv2_next     = dv2_reg;
        e1_next      = e1_reg;
        e2_next      = e2_reg;
        pfirst_next  = pfirst_reg;
        dn_next      = dn_reg;
        t_next       = t_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        s_next       = s_reg;
        x_next       = x_reg;
        r_next       = r_reg;
        bit_next     = bit_reg;
        tout_next    = tout_reg;
        zero_next    = zero_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_zero_next  = m_zero_reg;
        rd_addr      = slot_reg;
        sum_we       = 1'b0;
        sum_waddr    = corner_reg[idx_reg];
        sum_wdata    = '0;
        div_req      = '0;

        n_sel   = dn_reg[idx_reg + 2'd1];
        n_abs   = n_sel[36] ? 36'(-n_sel) : n_sel[35:0];
        det_abs = dn_reg[0][36] ? 36'(-dn_reg[0]) : dn_reg[0][35:0];
        q       = div_rsp.quotient;
        mag_or  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        trial   = r_reg + bit_reg;
        jstep   = 3'(step_reg - 5'd1);
        c_word  = '0;

        // Drop the result once taken.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // A load clears the sum of its slot.
        if (load_we) begin
            sum_we    = 1'b1;
            sum_waddr = in_slot;
            sum_wdata = '0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    slot_next   = in_slot;
                    corner_next = in_corner;
                    priority case (in_action)
                        ACT_TRI:  state_next = ST_TRD_A;
                        ACT_READ: state_next = ST_RRD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TRD_A: begin
                rd_addr    = corner_reg[0];
                state_next = ST_TRD_B;
            end
            ST_TRD_B: begin
                rd_addr    = corner_reg[1];
                pa_next    = pos_q;
                ta_next    = tex_q;
                state_next = ST_TRD_C;
            end
            ST_TRD_C: begin
                rd_addr    = corner_reg[2];
                pb_next    = pos_q;
                tb_next    = tex_q;
                state_next = ST_TCAP_C;
            end
            ST_TCAP_C: begin
                du1_next = cdiff(tb_reg[15:0],  ta_reg[15:0]);
                dv1_next = cdiff(tb_reg[31:16], ta_reg[31:16]);
                du2_next = cdiff(tex_q[15:0],   ta_reg[15:0]);
                dv2_next = cdiff(tex_q[31:16],  ta_reg[31:16]);
                for (int k = 0; k < 3; k++) begin
                    e1_next[k] = cdiff(pb_reg[16*k +: 16], pa_reg[16*k +: 16]);
                    e2_next[k] = cdiff(pos_q[16*k +: 16],  pa_reg[16*k +: 16]);
                end
                step_next  = '0;
                state_next = ST_TMUL;
            end
            ST_TMUL: begin
                // Products arrive in the cycle after their operands; pair them.
                if (step_reg != 5'd0) begin
                    if (!jstep[0]) begin
                        pfirst_next = prod_reg[35:0];
                    end else begin
                        dn_next[jstep[2:1]] = 37'(pfirst_reg)
                                            - 37'($signed(prod_reg[35:0]));
                    end
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd8) begin
                    idx_next   = '0;
                    state_next = (dn_reg[0] != '0) ? ST_TDIV_GO : ST_IDLE;
                end
            end
            ST_TDIV_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {n_abs, 12'd0};
                div_req.divisor  = det_abs;
                state_next       = ST_TDIV_WAIT;
            end
            ST_TDIV_WAIT: begin
                if (div_rsp.done) begin
                    if (n_sel[36] ^ dn_reg[0][36]) begin
                        t_next[idx_reg] = (q[47:31] != '0) ? 32'h8000_0000
                                                           : 32'(-q[31:0]);
                    end else begin
                        t_next[idx_reg] = (q[47:31] != '0) ? 32'h7FFF_FFFF : q[31:0];
                    end
                    if (idx_reg == 2'd2) begin
                        idx_next   = '0;
                        state_next = ST_SUM_RD;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_TDIV_GO;
                    end
                end
            end
            ST_SUM_RD: begin
                rd_addr    = corner_reg[idx_reg];
                state_next = ST_SUM_WR;
            end
            ST_SUM_WR: begin
                sum_we    = 1'b1;
                sum_waddr = corner_reg[idx_reg];
                sum_wdata = {sat_add(sum_q[95:64], t_reg[2]),
                             sat_add(sum_q[63:32], t_reg[1]),
                             sat_add(sum_q[31:0],  t_reg[0])};
                if (idx_reg == 2'd2) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_SUM_RD;
                end
            end
            ST_RRD: begin
                rd_addr    = slot_reg;
                state_next = ST_RCAP;
            end
            ST_RCAP: begin
                for (int k = 0; k < 3; k++) begin
                    c_word      = sum_q[32*k +: 32];
                    neg_next[k] = c_word[31];
                    mag_next[k] = c_word[31] ? 32'(-c_word) : c_word;
                end
                zero_next  = 1'b0;
                state_next = ST_RNORM;
            end
            ST_RNORM: begin
                // Shift all parts up together until the largest reaches 2^30.
                if (mag_or == '0) begin
                    zero_next  = 1'b1;
                    tout_next  = '{default: '0};
                    state_next = ST_OUT;
                end else if (mag_or[31:30] == 2'b00) begin
                    for (int k = 0; k < 3; k++) begin
                        mag_next[k] = {mag_reg[k][30:0], 1'b0};
                    end
                end else begin
                    s_next     = '0;
                    step_next  = '0;
                    state_next = ST_RSQ;
                end
            end
            ST_RSQ: begin
                step_next = step_reg + 5'd1;
                if (step_reg != 5'd0) begin
                    s_next = s_reg + prod_reg[63:0];
                end
                if (step_reg == 5'd3) begin
                    x_next     = s_reg + prod_reg[63:0];
                    r_next     = '0;
                    bit_next   = 64'h4000_0000_0000_0000;
                    step_next  = '0;
                    state_next = ST_RSQRT;
                end
            end
            ST_RSQRT: begin
                // One result bit per cycle.
                if (x_reg >= trial) begin
                    x_next = x_reg - trial;
                    r_next = {1'b0, r_reg[63:1]} + bit_reg;
                end else begin
                    r_next = {1'b0, r_reg[63:1]};
                end
                bit_next  = {2'b00, bit_reg[63:2]};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    idx_next   = '0;
                    state_next = ST_RDIV_GO;
                end
            end
            ST_RDIV_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {2'b00, mag_reg[idx_reg], 14'd0}
                                 + {17'd0, r_reg[31:1]};
                div_req.divisor  = {4'd0, r_reg[31:0]};
                state_next       = ST_RDIV_WAIT;
            end
            ST_RDIV_WAIT: begin
                if (div_rsp.done) begin
                    tout_next[idx_reg] = neg_reg[idx_reg] ? 16'(-q[15:0]) : q[15:0];
                    if (idx_reg == 2'd2) begin
                        state_next = ST_OUT;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_RDIV_GO;
                    end
                end
            end
            ST_OUT: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, tout_reg[2], tout_reg[1], tout_reg[0], slot_reg};
                    m_zero_next  = zero_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        corner_reg <= corner_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        du1_reg    <= du1_next;
        dv1_reg    <= dv1_next;
        du2_reg    <= du2_next;
        dv2_reg    <= dv2_next;
        e1_reg     <= e1_next;
        e2_reg     <= e2_next;
        pfirst_reg <= pfirst_next;
        dn_reg     <= dn_next;
        t_reg      <= t_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        s_reg      <= s_next;
        x_reg      <= x_next;
        r_reg      <= r_next;
        bit_reg    <= bit_next;
        tout_reg   <= tout_next;
        zero_reg   <= zero_next;
        m_data_reg <= m_data_next;
        m_zero_reg <= m_zero_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result appeared outside the output step");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_TDIV_WAIT || state_reg == ST_RDIV_WAIT))
        else $error("divider finished with no step waiting for it");

    a_det_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TDIV_GO |-> dn_reg[0] != '0)
        else $error("division started with a zero determinant");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid right after reset");

endmodule

// ----- sv/vta_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vta_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle
// when the quotient is ready.
// ----------------------------------------------------------------------------
module vta_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  vta_pkg::div_req_t  req,
    output vta_pkg::div_rsp_t  rsp
);
    import vta_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_BITS-1:0] num_reg, num_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0]  den_reg, den_next;
    logic [DIVISOR_BITS:0]    rem_sh;
    logic                     ge;

    always_comb begin
        rem_sh    = {rem_reg, num_reg[DIVIDEND_BITS-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? DIVISOR_BITS'(rem_sh - {1'b0, den_reg})
                          : rem_sh[DIVISOR_BITS-1:0];
            num_next = {num_reg[DIVIDEND_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(DIVIDEND_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

// ----- tb/vertex_tangent_accumulator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_tangent_accumulator_tb: self-checking bench for the tangent builder
// Loads vertices, adds triangles and reads back unit tangents. A scoreboard
// mirrors the vertex stores, predicts every read and checks each response
// field by field, under several phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
import vta_pkg::*;

typedef struct packed {
    logic [9:0]  vnum;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
    logic        zflag;
} tangent_rsp_t;

class tangent_scoreboard;
    logic signed [15:0] pos [VERTEX_COUNT][3];
    logic signed [15:0] uv [VERTEX_COUNT][2];
    longint sums [VERTEX_COUNT][3];
    tangent_rsp_t pending [$];
    int mismatches;

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint unsigned root64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function void add_triangle(int a, int b, int c);
        longint du1, dv1, du2, dv2, det, e1, e2, n;
        longint t [3];
        du1 = longint'(uv[b][0]) - uv[a][0];
        dv1 = longint'(uv[b][1]) - uv[a][1];
        du2 = longint'(uv[c][0]) - uv[a][0];
        dv2 = longint'(uv[c][1]) - uv[a][1];
        det = du1 * dv2 - du2 * dv1;
        for (int k = 0; k < 3; k++) begin
            t[k] = 0;
            if (det != 0) begin
                e1 = longint'(pos[b][k]) - pos[a][k];
                e2 = longint'(pos[c][k]) - pos[a][k];
                n = dv2 * e1 - dv1 * e2;
                t[k] = clamp32((n * 4096) / det);
            end
        end
        for (int k = 0; k < 3; k++) begin
            sums[a][k] = clamp32(sums[a][k] + t[k]);
            sums[b][k] = clamp32(sums[b][k] + t[k]);
            sums[c][k] = clamp32(sums[c][k] + t[k]);
        end
    endfunction

    function tangent_rsp_t unit_tangent(int v);
        tangent_rsp_t r;
        longint unsigned mag [3];
        longint unsigned m, s, len, q;
        bit neg [3];
        m = 0;
        s = 0;
        r = '0;
        r.vnum = v[9:0];
        for (int k = 0; k < 3; k++) begin
            neg[k] = sums[v][k] < 0;
            mag[k] = neg[k] ? -sums[v][k] : sums[v][k];
            if (mag[k] > m) m = mag[k];
        end
        if (m == 0) begin
            r.zflag = 1'b1;
            return r;
        end
        while (m < (64'd1 << 30)) begin
            m <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
        end
        for (int k = 0; k < 3; k++) s += mag[k] * mag[k];
        len = root64(s);
        for (int k = 0; k < 3; k++) begin
            q = (mag[k] * 16384 + len / 2) / len;
            if (neg[k]) q = -q;
            if (k == 0) r.tx = q[15:0];
            else if (k == 1) r.ty = q[15:0];
            else r.tz = q[15:0];
        end
        return r;
    endfunction

    // Note one accepted request and queue the response it causes, if any.
    function void note_request(logic [1:0] act, logic [127:0] d);
        int slot;
        slot = d[9:0];
        case (action_t'(act))
            ACT_LOAD: begin
                pos[slot][0] = d[25:10];
                pos[slot][1] = d[41:26];
                pos[slot][2] = d[57:42];
                uv[slot][0] = d[73:58];
                uv[slot][1] = d[89:74];
                for (int k = 0; k < 3; k++) sums[slot][k] = 0;
            end
            ACT_TRI: add_triangle(d[99:90], d[109:100], d[119:110]);
            ACT_READ: pending = {pending, unit_tangent(slot)};
            default: ;
        endcase
    endfunction

    function void check_response(logic [63:0] d, logic z);
        tangent_rsp_t got, exp_r;
        got = {d[9:0], d[25:10], d[41:26], d[57:42], z};
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp v=%0d t=%h %h %h z=%b got v=%0d t=%h %h %h z=%b",
                         exp_r.vnum, exp_r.tx, exp_r.ty, exp_r.tz, exp_r.zflag,
                         got.vnum, got.tx, got.ty, got.tz, got.zflag);
        end
    endfunction
endclass

module vertex_tangent_accumulator_tb;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;

    tangent_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    // Slots loaded so far; reads and triangles only name these.
    bit loaded [VERTEX_COUNT];
    int loaded_list [$];

    vertex_tangent_accumulator dut (.*);

    always #5 aclk = ~aclk;

    // Hard limit: even with 87% idle and stall, 1600 requests stay well under
    // 5 ms.
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // Receiver: stall at random, score each response on the accept edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_response(m_tdata, m_tuser[0]);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one request: idle at random first, then hold valid until accepted.
    // Valid stays high into the next request when no idle cycle follows.
    task automatic send_request(logic [1:0] act, logic [127:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_request(act, d);
    endtask

    task automatic load_vertex(int slot, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic [15:0] u, logic [15:0] v);
        logic [127:0] d;
        d = '0;
        d[9:0] = slot[9:0];
        d[25:10] = x;
        d[41:26] = y;
        d[57:42] = z;
        d[73:58] = u;
        d[89:74] = v;
        // Fill the triangle fields with noise; a load ignores them.
        d[119:90] = 30'($urandom);
        if (!loaded[slot]) loaded_list = {loaded_list, slot};
        loaded[slot] = 1'b1;
        send_request(ACT_LOAD, d);
    endtask

    task automatic add_tri(int a, int b, int c);
        logic [127:0] d;
        d = {$urandom, $urandom, $urandom, $urandom};
        d[127:120] = '0;
        d[99:90] = a[9:0];
        d[109:100] = b[9:0];
        d[119:110] = c[9:0];
        send_request(ACT_TRI, d);
    endtask

    task automatic read_vertex(int slot);
        logic [127:0] d;
        d = {$urandom, $urandom, $urandom, $urandom};
        d[127:120] = '0;
        d[9:0] = slot[9:0];
        send_request(ACT_READ, d);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(16'h0800) - 16'h0400);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    task automatic random_request();
        int r, a, b, c;
        r = $urandom_range(99);
        if (r < 30 || loaded_list.size() < 3) begin
            load_vertex($urandom_range(1023), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord());
        end else if (r < 65) begin
            a = pick_loaded();
            b = pick_loaded();
            c = ($urandom_range(9) == 0) ? a : pick_loaded();
            add_tri(a, b, c);
        end else if (r < 95) begin
            read_vertex(pick_loaded());
        end else begin
            send_request(ACT_NOP, {$urandom, $urandom, $urandom, 32'h0});
        end
    endtask

    initial begin
        int idle_pct [4] = '{0, 87, 0, 32};
        int stall_pct [4] = '{0, 0, 87, 32};
        int wait_cycles;
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, every action, repeated corners, zero sums,
        // zero determinant, saturation and out-of-range-looking indexes.
        load_vertex(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        load_vertex(1, 16'h1000, 16'h0000, 16'h0000, 16'h1000, 16'h0000);
        load_vertex(2, 16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h1000);
        read_vertex(0);
        add_tri(0, 1, 2);
        read_vertex(0);
        read_vertex(2);
        add_tri(0, 0, 1);
        load_vertex(1023, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        load_vertex(1022, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        load_vertex(1021, 16'h7fff, 16'h7fff, 16'h8000, 16'h7ffe, 16'h8000);
        for (int i = 0; i < 4; i++) add_tri(1023, 1022, 1021);
        read_vertex(1023);
        read_vertex(1021);
        load_vertex(3, 16'h1000, 16'h1000, 16'h0000, 16'h1000, 16'h1000);
        add_tri(0, 3, 1);
        read_vertex(3);
        send_request(ACT_NOP, '1 >> 8);
        read_vertex(1);
        load_vertex(1023, 16'h0001, 16'hffff, 16'h0000, 16'h0001, 16'hffff);
        read_vertex(1023);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = idle_pct[phase];
            recv_stall_pct = stall_pct[phase];
            for (int i = 0; i < 385; i++) random_request();
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (300) @(posedge aclk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
